@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that a condition implies a consequence in the same cycle.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ hw/rtl/tlsdr_pkg.sv @@
`timescale 1ns / 1ps
package tlsdr_pkg;
  localparam int unsigned COMP_WIDTH_DEF = 16;
  localparam int unsigned KNEE_Q14 = 40125;
  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_PICKUP_LOW = 2'd0;
  localparam logic [1:0] REG_PICKUP_BASE = 2'd1;
  localparam logic [1:0] REG_RATED = 2'd2;
  localparam logic [1:0] REG_DELAY = 2'd3;
  localparam int unsigned NUM_MAGS = 9;
  localparam int unsigned MAG_IDX_W = 4;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOAD = 5'b00010,
    ST_SQRT = 5'b00100,
    ST_EVAL = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  typedef enum logic [3:0] {
    SQ_IDLE = 4'b0001,
    SQ_RE   = 4'b0010,
    SQ_IM   = 4'b0100,
    SQ_ROOT = 4'b1000
  } sq_phase_t;

  typedef struct packed {
    logic load;
    logic mag_start;
    logic [MAG_IDX_W-1:0] mag_idx;
    logic eval;
  } cmd_t;

  typedef struct packed {
    logic mag_done;
  } stat_t;
endpackage

@@ hw/rtl/tlsdr_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tlsdr_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic out_fire,
  input  tlsdr_pkg::stat_t stat,
  output tlsdr_pkg::cmd_t cmd,
  output logic busy,
  output logic out_valid
);
  tlsdr_pkg::state_t state, state_next;
  logic [tlsdr_pkg::MAG_IDX_W-1:0] idx, idx_next;

  // Advance through load, nine roots, evaluate, deliver
  always_comb begin
    state_next = state;
    idx_next = idx;
    cmd = '0;
    cmd.mag_idx = idx;
    unique case (state)
      tlsdr_pkg::ST_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = tlsdr_pkg::ST_LOAD;
        end
      end
      tlsdr_pkg::ST_LOAD: begin
        cmd.mag_start = 1'b1;
        cmd.mag_idx = '0;
        idx_next = '0;
        state_next = tlsdr_pkg::ST_SQRT;
      end
      tlsdr_pkg::ST_SQRT: begin
        if (stat.mag_done) begin
          if (idx == tlsdr_pkg::MAG_IDX_W'(tlsdr_pkg::NUM_MAGS - 1)) begin
            state_next = tlsdr_pkg::ST_EVAL;
          end else begin
            idx_next = idx + 1'b1;
            cmd.mag_idx = idx + 1'b1;
            cmd.mag_start = 1'b1;
          end
        end
      end
      tlsdr_pkg::ST_EVAL: begin
        cmd.eval = 1'b1;
        state_next = tlsdr_pkg::ST_OUT;
      end
      tlsdr_pkg::ST_OUT: begin
        if (out_fire) begin
          state_next = tlsdr_pkg::ST_IDLE;
        end
      end
      default: state_next = tlsdr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlsdr_pkg::ST_IDLE;
      idx <= '0;
    end else begin
      state <= state_next;
      idx <= idx_next;
    end
  end

  assign busy = (state != tlsdr_pkg::ST_IDLE);
  assign out_valid = (state == tlsdr_pkg::ST_OUT);

  `ASSERT_NEXT(a_load_next, clk, rst, in_fire && !busy, state == tlsdr_pkg::ST_LOAD)
  `ASSERT_IMP(a_idx_range, clk, rst, state == tlsdr_pkg::ST_SQRT, idx < tlsdr_pkg::MAG_IDX_W'(tlsdr_pkg::NUM_MAGS))
  `ASSERT_NEXT(a_out_idle, clk, rst, out_fire, state == tlsdr_pkg::ST_IDLE)
endmodule

@@ hw/rtl/tlsdr_datapath.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tlsdr_datapath #(
  parameter int unsigned COMP_WIDTH = tlsdr_pkg::COMP_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  tlsdr_pkg::cmd_t cmd,
  output tlsdr_pkg::stat_t stat,
  input  logic [31:0] low_a_phasor,
  input  logic [31:0] low_b_phasor,
  input  logic [31:0] low_c_phasor,
  input  logic [31:0] wind_a_phasor,
  input  logic [31:0] wind_b_phasor,
  input  logic [31:0] wind_c_phasor,
  input  logic [15:0] elapsed_ticks,
  input  logic [15:0] pickup_low,
  input  logic [15:0] pickup_base,
  input  logic [14:0] rated,
  input  logic [15:0] delay,
  output logic trip,
  output logic pickup_a,
  output logic pickup_b,
  output logic pickup_c
);
  localparam int unsigned CW = (COMP_WIDTH < 16) ? COMP_WIDTH : 16;
  // Square sums stay below 2^37; root fits 19 bits
  localparam int unsigned SQ_W = 38;
  localparam int unsigned RT_W = 19;
  localparam int unsigned STEPS = SQ_W / 2;

  logic signed [17:0] re [9];
  logic signed [17:0] im [9];
  logic [15:0] ticks;
  logic [RT_W-1:0] mags [9];

  function automatic logic signed [17:0] comp(input logic [15:0] h);
    logic [CW-1:0] v;
    v = h[CW-1:0];
    return 18'(signed'(v));
  endfunction

  // Capture operands: 3 diffs, 3 low, 3 wind
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ticks <= elapsed_ticks;
      re[3] <= comp(low_a_phasor[31:16]); im[3] <= comp(low_a_phasor[15:0]);
      re[4] <= comp(low_b_phasor[31:16]); im[4] <= comp(low_b_phasor[15:0]);
      re[5] <= comp(low_c_phasor[31:16]); im[5] <= comp(low_c_phasor[15:0]);
      re[6] <= comp(wind_a_phasor[31:16]); im[6] <= comp(wind_a_phasor[15:0]);
      re[7] <= comp(wind_b_phasor[31:16]); im[7] <= comp(wind_b_phasor[15:0]);
      re[8] <= comp(wind_c_phasor[31:16]); im[8] <= comp(wind_c_phasor[15:0]);
      re[0] <= comp(low_a_phasor[31:16]) + comp(wind_a_phasor[31:16])
             - comp(wind_c_phasor[31:16]);
      im[0] <= comp(low_a_phasor[15:0]) + comp(wind_a_phasor[15:0])
             - comp(wind_c_phasor[15:0]);
      re[1] <= comp(low_b_phasor[31:16]) + comp(wind_b_phasor[31:16])
             - comp(wind_a_phasor[31:16]);
      im[1] <= comp(low_b_phasor[15:0]) + comp(wind_b_phasor[15:0])
             - comp(wind_a_phasor[15:0]);
      re[2] <= comp(low_c_phasor[31:16]) + comp(wind_c_phasor[31:16])
             - comp(wind_b_phasor[31:16]);
      im[2] <= comp(low_c_phasor[15:0]) + comp(wind_c_phasor[15:0])
             - comp(wind_b_phasor[15:0]);
    end
  end

  // Shared square unit then bit-pair root iteration
  logic [17:0] ar, ai, sq_op;
  logic [35:0] sq_prod;
  logic [SQ_W-1:0] acc;
  logic [RT_W-1:0] root;
  logic [RT_W+1:0] prem, prem_sh;
  logic [4:0] step;
  tlsdr_pkg::sq_phase_t phase;
  logic [tlsdr_pkg::MAG_IDX_W-1:0] cur;

  assign ar = re[cur][17] ? 18'(-re[cur]) : 18'(re[cur]);
  assign ai = im[cur][17] ? 18'(-im[cur]) : 18'(im[cur]);
  assign sq_op = (phase == tlsdr_pkg::SQ_IM) ? ai : ar;
  assign sq_prod = 36'(sq_op) * 36'(sq_op);

  // Bring down the next two bits of the square sum
  assign prem_sh = {prem[RT_W-1:0], acc[SQ_W-1 -: 2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tlsdr_pkg::SQ_IDLE;
      stat.mag_done <= 1'b0;
    end else begin
      stat.mag_done <= 1'b0;
      unique case (phase)
        tlsdr_pkg::SQ_IDLE: begin
          if (cmd.mag_start) begin
            cur <= cmd.mag_idx;
            phase <= tlsdr_pkg::SQ_RE;
          end
        end
        tlsdr_pkg::SQ_RE: begin
          acc <= SQ_W'(sq_prod);
          phase <= tlsdr_pkg::SQ_IM;
        end
        tlsdr_pkg::SQ_IM: begin
          acc <= acc + SQ_W'(sq_prod);
          prem <= '0;
          root <= '0;
          step <= '0;
          phase <= tlsdr_pkg::SQ_ROOT;
        end
        tlsdr_pkg::SQ_ROOT: begin
          if (prem_sh >= {root, 2'b01}) begin
            prem <= prem_sh - {root, 2'b01};
            root <= {root[RT_W-2:0], 1'b1};
          end else begin
            prem <= prem_sh;
            root <= {root[RT_W-2:0], 1'b0};
          end
          acc <= {acc[SQ_W-3:0], 2'b00};
          step <= step + 1'b1;
          if (step == 5'(STEPS - 1)) begin
            phase <= tlsdr_pkg::SQ_IDLE;
            stat.mag_done <= 1'b1;
          end
        end
        default: phase <= tlsdr_pkg::SQ_IDLE;
      endcase
    end
  end

  // Latch the finished root; result of the last step lands here
  logic fin;
  always_ff @(posedge clk) begin
    if (rst) fin <= 1'b0;
    else fin <= (phase == tlsdr_pkg::SQ_ROOT) && (step == 5'(STEPS - 1));
    if (fin) mags[cur] <= root;
  end

  // Knee compare scaled by 2^15; slope compare scaled by 2^16
  logic [30:0] half_knee;
  logic [2:0] pk;
  assign half_knee = 31'(rated) * 31'(tlsdr_pkg::KNEE_Q14);

  for (genvar p = 0; p < 3; p++) begin : g_phase
    logic [RT_W-1:0] ir;
    logic [RT_W+14:0] irs;
    logic [RT_W+15:0] lhs, rhs;
    assign ir = (mags[3+p] > mags[6+p]) ? mags[3+p] : mags[6+p];
    assign irs = {ir, 15'd0};
    assign lhs = {mags[p], 16'd0};
    assign rhs = (RT_W+16)'(irs - (RT_W+15)'(half_knee))
               + (RT_W+16)'({pickup_base, 16'd0});
    assign pk[p] = (irs <= (RT_W+15)'(half_knee)) ? (mags[p] > RT_W'(pickup_low))
                                                   : (lhs > rhs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trip <= 1'b0;
    end else if (cmd.eval && (pk[0] || pk[1] || pk[2]) && ticks > delay) begin
      trip <= 1'b1;
    end
    if (cmd.eval) begin
      pickup_a <= pk[0];
      pickup_b <= pk[1];
      pickup_c <= pk[2];
    end
  end

  `ASSERT_NEXT(a_trip_sticky, clk, rst, trip, trip)
  `ASSERT_IMP(a_start_idle, clk, rst, cmd.mag_start, phase == tlsdr_pkg::SQ_IDLE || stat.mag_done)
endmodule

@@ hw/rtl/transformer_low_side_diff_relay.sv @@
`timescale 1ns / 1ps
// An input word is loaded, its nine magnitudes are then formed one after another, and
// the last root status, the evaluation and the result follow in that order.
// A new input word is taken only once the result word has been taken; the single
// shared square and root unit sets the rate.
// Reset (rst, synchronous): clears trip latch, state, registers to defaults (delay 200).
module transformer_low_side_diff_relay #(
  parameter int unsigned COMP_WIDTH = tlsdr_pkg::COMP_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [tlsdr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic in_valid,
  output logic in_ready,
  input  logic [31:0] low_a_phasor,
  input  logic [31:0] low_b_phasor,
  input  logic [31:0] low_c_phasor,
  input  logic [31:0] wind_a_phasor,
  input  logic [31:0] wind_b_phasor,
  input  logic [31:0] wind_c_phasor,
  input  logic [15:0] elapsed_ticks,
  output logic out_valid,
  input  logic out_ready,
  output logic trip,
  output logic pickup_a,
  output logic pickup_b,
  output logic pickup_c
);
  logic [15:0] pickup_low, pickup_base, delay;
  logic [14:0] rated;
  logic busy;
  tlsdr_pkg::cmd_t cmd;
  tlsdr_pkg::stat_t stat;

  assign pready = 1'b1;
  assign in_ready = !busy;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pickup_low <= '0;
      pickup_base <= '0;
      rated <= '0;
      delay <= 16'd200;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (paddr[3:2])
        tlsdr_pkg::REG_PICKUP_LOW: pickup_low <= pwdata[15:0];
        tlsdr_pkg::REG_PICKUP_BASE: pickup_base <= pwdata[15:0];
        tlsdr_pkg::REG_RATED: rated <= pwdata[14:0];
        tlsdr_pkg::REG_DELAY: delay <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[3:2])
      tlsdr_pkg::REG_PICKUP_LOW: prdata = {16'd0, pickup_low};
      tlsdr_pkg::REG_PICKUP_BASE: prdata = {16'd0, pickup_base};
      tlsdr_pkg::REG_RATED: prdata = {17'd0, rated};
      tlsdr_pkg::REG_DELAY: prdata = {16'd0, delay};
      default: prdata = '0;
    endcase
  end

  tlsdr_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_fire(in_valid && !busy),
    .out_fire(out_valid && out_ready),
    .stat(stat), .cmd(cmd), .busy(busy), .out_valid(out_valid)
  );

  tlsdr_datapath #(.COMP_WIDTH(COMP_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .low_a_phasor(low_a_phasor), .low_b_phasor(low_b_phasor),
    .low_c_phasor(low_c_phasor), .wind_a_phasor(wind_a_phasor),
    .wind_b_phasor(wind_b_phasor), .wind_c_phasor(wind_c_phasor),
    .elapsed_ticks(elapsed_ticks),
    .pickup_low(pickup_low), .pickup_base(pickup_base),
    .rated(rated), .delay(delay),
    .trip(trip), .pickup_a(pickup_a), .pickup_b(pickup_b), .pickup_c(pickup_c)
  );
endmodule
